// ===== rtl/pat_pkg.sv =====
// pat_pkg: shared types, codes and defaults for the page allocation table
// used by pat_ctrl, pat_dpath and page_allocation_table
package pat_pkg;

  localparam int PAT_NUM_PAGES = 32;
  localparam int PAT_PAGE_SIZE = 100;
  localparam int PAT_NUM_IDS   = 256;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_PRESENT  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  prog_id;
    logic [11:0] req_size;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  page_count;
    logic [11:0] prog_size;
    logic [31:0] page_mask;
    logic [6:0]  free_pages;
  } out_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic scan;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/pat_ram.sv =====
// pat_ram: generic single write port, single read port ram with registered read
// no dependencies
module pat_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pat_ctrl.sv =====
// pat_ctrl: sequencing state machine for the page allocation table
// depends on pat_pkg for the command and status structs
module pat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pat_pkg::ctl_sts_t sts,
  output pat_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    req_stall    = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.decide = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/pat_dpath.sv =====
// pat_dpath: page owner table, id records, free space and result register
// depends on pat_pkg and pat_ram
module pat_dpath #(
  parameter int NUM_PAGES = pat_pkg::PAT_NUM_PAGES,
  parameter int PAGE_SIZE = pat_pkg::PAT_PAGE_SIZE,
  parameter int NUM_IDS   = pat_pkg::PAT_NUM_IDS
) (
  input  logic              clk,
  input  logic              rst,
  input  pat_pkg::in_t      req,
  input  pat_pkg::ctl_cmd_t cmd,
  output pat_pkg::ctl_sts_t sts,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pat_pkg::out_t     rsp
);

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam int FU_W  = $clog2(NUM_PAGES * PAGE_SIZE + 1);
  localparam int ID_W  = $clog2(NUM_IDS);
  localparam int CMP_W = (FU_W > 12) ? FU_W : 12;

  logic [1:0]       kind_r;
  logic [7:0]       id_r;
  logic [11:0]      size_r;
  logic [1:0]       status_r;
  logic [11:0]      psize_r;
  logic             report_r;
  logic             op_alloc;
  logic             op_free;
  logic [11:0]      remaining;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count_acc;
  logic [31:0]      mask_acc;
  logic [CNT_W-1:0] free_cnt;
  logic [FU_W-1:0]  free_units;
  logic [7:0]       page_owner [NUM_PAGES];
  logic [NUM_IDS-1:0] prog_present;
  logic [11:0]      len_rdata;

  logic        usable;
  logic        present;
  logic        no_space;
  logic        alloc_go;
  logic        free_go;
  logic [1:0]  status_next;
  logic [7:0]  owner;
  logic        take;
  logic        drop;
  logic        match;

  pat_ram #(
    .WIDTH(12),
    .DEPTH(NUM_IDS)
  ) u_len (
    .clk  (clk),
    .we   (cmd.decide && alloc_go),
    .waddr(id_r[ID_W-1:0]),
    .wdata(size_r),
    .re   (cmd.capture),
    .raddr(req.prog_id[ID_W-1:0]),
    .rdata(len_rdata)
  );

  // request decode
  always_comb begin
    usable   = (id_r != 8'd0) && ({1'b0, id_r} < 9'(NUM_IDS));
    present  = usable && prog_present[id_r[ID_W-1:0]];
    no_space = CMP_W'(size_r) > CMP_W'(free_units);
    alloc_go = (kind_r == pat_pkg::KIND_ALLOC) && !no_space && usable && !present;
    free_go  = (kind_r == pat_pkg::KIND_FREE) && present;
    case (kind_r)
      pat_pkg::KIND_ALLOC: begin
        if (no_space) begin
          status_next = pat_pkg::ST_NOSPACE;
        end else if (!usable || present) begin
          status_next = pat_pkg::ST_PRESENT;
        end else begin
          status_next = pat_pkg::ST_OK;
        end
      end
      default: begin
        status_next = present ? pat_pkg::ST_OK : pat_pkg::ST_NOTFOUND;
      end
    endcase
  end

  // one page entry per scan cycle
  always_comb begin
    owner = page_owner[idx];
    take  = op_alloc && (owner == 8'd0) && (remaining != 12'd0);
    drop  = op_free && (owner == id_r);
    match = report_r && ((owner == id_r) || take);
  end

  assign sts.scan_last = (idx == IDX_W'(NUM_PAGES - 1));
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= req.kind;
      id_r   <= req.prog_id;
      size_r <= req.req_size;
    end
    if (cmd.decide) begin
      status_r  <= status_next;
      report_r  <= alloc_go || present;
      psize_r   <= alloc_go ? size_r : (present ? len_rdata : 12'd0);
      remaining <= alloc_go ? size_r : 12'd0;
      idx       <= '0;
      count_acc <= '0;
      mask_acc  <= '0;
    end
    if (cmd.scan) begin
      if (take) begin
        remaining <= (remaining <= 12'(PAGE_SIZE)) ? 12'd0 : remaining - 12'(PAGE_SIZE);
      end
      if (match) begin
        count_acc  <= count_acc + CNT_W'(1);
        mask_acc[idx] <= 1'b1;
      end
      if (!sts.scan_last) begin
        idx <= idx + IDX_W'(1);
      end
    end
    if (cmd.load_out) begin
      rsp.status     <= status_r;
      rsp.page_count <= 7'(count_acc);
      rsp.prog_size  <= psize_r;
      rsp.page_mask  <= op_free ? 32'd0 : mask_acc;
      rsp.free_pages <= 7'(free_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_alloc     <= 1'b0;
      op_free      <= 1'b0;
      free_cnt     <= CNT_W'(NUM_PAGES);
      free_units   <= FU_W'(NUM_PAGES * PAGE_SIZE);
      prog_present <= '0;
      rsp_valid    <= 1'b0;
      for (int i = 0; i < NUM_PAGES; i++) begin
        page_owner[i] <= 8'd0;
      end
    end else begin
      if (cmd.decide) begin
        op_alloc <= alloc_go;
        op_free  <= free_go;
        if (alloc_go) begin
          prog_present[id_r[ID_W-1:0]] <= 1'b1;
        end
        if (free_go) begin
          prog_present[id_r[ID_W-1:0]] <= 1'b0;
        end
      end
      if (cmd.scan) begin
        if (take) begin
          page_owner[idx] <= id_r;
          free_cnt        <= free_cnt - CNT_W'(1);
          free_units      <= free_units - FU_W'(PAGE_SIZE);
        end else if (drop) begin
          page_owner[idx] <= 8'd0;
          free_cnt        <= free_cnt + CNT_W'(1);
          free_units      <= free_units + FU_W'(PAGE_SIZE);
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_free_cnt_range: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CNT_W'(NUM_PAGES))
    else $error("free page count above pool size");

  a_free_units_track: assert property (@(posedge clk) disable iff (rst)
    free_units == FU_W'(FU_W'(free_cnt) * FU_W'(PAGE_SIZE)))
    else $error("free units out of step with free page count");

  a_alloc_complete: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> remaining == 12'd0)
    else $error("allocation scan ended with pages still owed");

  a_result_follows_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("result register not valid after load");

endmodule

// ===== rtl/page_allocation_table.sv =====
// page_allocation_table: top level, first fit page allocator over a fixed pool
// depends on pat_pkg, pat_ctrl, pat_dpath and pat_ram
//
// Each request (allocate, free or query of a program id) yields one result.
// A request passes through the id record read, a walk over the page owner
// table, one page entry per cycle, and the load of the result into the output
// register; the load waits while the previous result still waits on rsp_stall.
// The next request is taken in the cycle after the load, while the result may
// still wait in the output register.
// No clearing pass is needed after reset.
module page_allocation_table #(
  parameter int NUM_PAGES = pat_pkg::PAT_NUM_PAGES,
  parameter int PAGE_SIZE = pat_pkg::PAT_PAGE_SIZE,
  parameter int NUM_IDS   = pat_pkg::PAT_NUM_IDS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pat_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pat_pkg::out_t rsp
);

  pat_pkg::ctl_cmd_t cmd;
  pat_pkg::ctl_sts_t sts;

  pat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pat_dpath #(
    .NUM_PAGES(NUM_PAGES),
    .PAGE_SIZE(PAGE_SIZE),
    .NUM_IDS  (NUM_IDS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule
